### sv/nie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nie_pkg
// Shared types, constants and saturating arithmetic for the Newton
// interpolation error block.
// ----------------------------------------------------------------------------
package nie_pkg;

  localparam int MAX_NODES     = 16;
  localparam int FRACTION_BITS = 40;
  localparam int NODE_AW       = $clog2(MAX_NODES);
  localparam int POS_W         = 32;
  localparam int VAL_W         = 64;
  localparam int DIFF_W        = POS_W + 1;
  localparam int PROD_W        = VAL_W + DIFF_W;
  localparam int DEG_W         = 4;
  localparam int IDX_W         = 4;
  localparam int DD_SH         = 30;
  localparam int RUNGE_SH      = 60 - FRACTION_BITS;
  localparam int RUNGE_K       = 25;
  localparam int DIV_STEPS     = 2 * VAL_W;
  localparam int DIV_CW        = $clog2(DIV_STEPS);
  localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(8);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_READY  = 2'd1,
    STAT_COINCIDENT = 2'd2,
    STAT_INDEX      = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_CK_RI, S_CK_LI, S_CK_CMP,
    S_RG_RD, S_RG_LD, S_RG_MS, S_RG_MW, S_RG_DEN, S_RG_DS, S_RG_DW, S_RG_END,
    S_DD_RA, S_DD_RB, S_DD_RC, S_DD_DS, S_DD_DW,
    S_EV_R0, S_EV_L0, S_EV_RA, S_EV_RB, S_EV_MS, S_EV_MW, S_EV_NG, S_EV_AD,
    S_EV_E1, S_EV_E2
  } state_t;

  typedef enum logic [1:0] {
    DP_IDLE, DP_RUN, DP_ROUND, DP_OUT
  } div_phase_t;

  typedef struct packed {
    logic                 start;
    logic [VAL_W-1:0]     a_mag;
    logic [DIFF_W-1:0]    b_mag;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [PROD_W-1:0]    prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [VAL_W-1:0]     a;
    logic [VAL_W-1:0]     b;
    logic                 sh_dd;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [VAL_W-1:0]     q;
  } div_rsp_t;

  typedef struct packed {
    logic                 node_we;
    logic [NODE_AW-1:0]   node_waddr;
    logic [POS_W-1:0]     node_wdata;
    logic [NODE_AW-1:0]   node_raddr;
    logic                 diff_we;
    logic [NODE_AW-1:0]   diff_waddr;
    logic [VAL_W-1:0]     diff_wdata;
    logic [NODE_AW-1:0]   diff_raddr;
  } mem_ctl_t;

  function automatic logic [VAL_W-1:0] mag64(input logic [VAL_W-1:0] a);
    return a[VAL_W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic [VAL_W-1:0] signed_sat(input logic neg,
                                                  input logic [VAL_W-1:0] m);
    if (!neg) return m[VAL_W-1] ? VAL_MAX : m;
    if (m[VAL_W-1]) return VAL_MIN;
    return ~m + 1'b1;
  endfunction

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
    return s[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/newton_interpolation_error.sv
`default_nettype none
// ----------------------------------------------------------------------------
// newton_interpolation_error
// Newton divided-difference interpolation of 1/(1+25x^2) with error report.
// Node loads below the degree index: the dispatch state sets the registered result.
// Final node load (n = degree): a pairwise compare of all nodes, then (n+1)
// function samples and n(n+1)/2 quotients, each a pass of the 128-step divider.
// Evaluate: one multiply per Horner step on the shared multiplier, plus one
// function sample with a divider pass; one item at a time, busy high until its strobe.
// Synchronous reset: table not ready, degree 8; memories hold no reset.
// ----------------------------------------------------------------------------
module newton_interpolation_error (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [nie_pkg::IDX_W-1:0]     in_node_index,
  input  wire logic [nie_pkg::POS_W-1:0]     in_position,
  output logic                               out_strobe,
  output logic [1:0]                         out_status,
  output logic [nie_pkg::VAL_W-1:0]          out_interpolated_value,
  output logic [nie_pkg::VAL_W-2:0]          out_error_magnitude,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [nie_pkg::DEG_W-1:0]     cfg_degree
);
  import nie_pkg::*;

  localparam logic [PROD_W:0]    MUL_HALF = (PROD_W+1)'(1) << (DD_SH - 1);
  localparam logic [VAL_W-1:0]   RG_HALF  = VAL_W'(1) << (RUNGE_SH - 1);

  state_t              state_r, state_nxt;
  logic [DEG_W-1:0]    degree_r, degree_nxt;
  logic                ready_r, ready_nxt;
  logic                op_r, op_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0]    x_r, x_nxt, ni_r, ni_nxt;
  logic [NODE_AW-1:0]  i_r, i_nxt, j_r, j_nxt, n;
  logic [VAL_W-1:0]    a_r, a_nxt, v_r, v_nxt, num_r, num_nxt;
  logic [VAL_W-1:0]    sq_r, sq_nxt, den_r, den_nxt, fx_r, fx_nxt;
  logic [VAL_W-1:0]    rm_r, rm_nxt, p_r, p_nxt;
  logic [DIFF_W-1:0]   d_r, d_nxt;
  logic                neg_r, neg_nxt;
  logic [VAL_W:0]      e_r, e_nxt;
  logic                strobe_r, strobe_nxt;
  status_t             status_r, status_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [VAL_W-2:0]    err_r, err_nxt;

  mem_ctl_t            mctl;
  mul_req_t            mreq;
  mul_rsp_t            mrsp;
  div_req_t            dreq;
  div_rsp_t            drsp;
  logic [POS_W-1:0]    node_rdata;
  logic [VAL_W-1:0]    diff_rdata;

  logic [PROD_W:0]     mul_t, mul_tsh;
  logic                mul_ovf;
  logic [VAL_W-1:0]    rg_sq;
  logic [POS_W-1:0]    x_mag;
  logic [DIFF_W-1:0]   d_mag, ev_d, dd_d;
  logic [VAL_W:0]      e_mag;
  logic                accept, cfg_wr;

  nie_mem u_mem (.clk, .ctl(mctl), .node_rdata, .diff_rdata);
  nie_mul u_mul (.clk, .rst_n, .req(mreq), .rsp(mrsp));
  nie_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (int'(degree_r) > MAX_NODES - 1) n = NODE_AW'(MAX_NODES - 1);
    else n = NODE_AW'(degree_r);
  end

  assign mul_t   = {1'b0, mrsp.prod} + MUL_HALF;
  assign mul_tsh = mul_t >> DD_SH;
  assign mul_ovf = |mul_tsh[PROD_W:VAL_W];
  assign rg_sq   = (mrsp.prod[VAL_W-1:0] + RG_HALF) >> RUNGE_SH;
  assign x_mag   = x_r[POS_W-1] ? (~x_r + 1'b1) : x_r;
  assign d_mag   = d_r[DIFF_W-1] ? (~d_r + 1'b1) : d_r;
  assign ev_d    = {x_r[POS_W-1], x_r} - {node_rdata[POS_W-1], node_rdata};
  assign dd_d    = {ni_r[POS_W-1], ni_r} - {node_rdata[POS_W-1], node_rdata};
  assign e_mag   = e_r[VAL_W] ? (~e_r + 1'b1) : e_r;

  always_comb begin
    state_nxt  = state_r;
    degree_nxt = degree_r;
    ready_nxt  = ready_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    x_nxt      = x_r;
    ni_nxt     = ni_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    a_nxt      = a_r;
    v_nxt      = v_r;
    num_nxt    = num_r;
    sq_nxt     = sq_r;
    den_nxt    = den_r;
    fx_nxt     = fx_r;
    rm_nxt     = rm_r;
    p_nxt      = p_r;
    d_nxt      = d_r;
    neg_nxt    = neg_r;
    e_nxt      = e_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    val_nxt    = val_r;
    err_nxt    = err_r;
    mctl       = '0;
    mreq       = '0;
    dreq       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_wr) begin
          degree_nxt = cfg_degree;
          ready_nxt  = 1'b0;
        end
        if (accept) begin
          op_nxt    = in_op;
          idx_nxt   = in_node_index;
          x_nxt     = in_position;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        if (op_r == OP_LOAD) begin
          if (int'(idx_r) > int'(n)) begin
            strobe_nxt = 1'b1;
            status_nxt = STAT_INDEX;
            val_nxt    = '0;
            err_nxt    = '0;
            state_nxt  = S_IDLE;
          end else begin
            mctl.node_we    = 1'b1;
            mctl.node_waddr = NODE_AW'(idx_r);
            mctl.node_wdata = x_r;
            ready_nxt       = 1'b0;
            if (int'(idx_r) == int'(n)) begin
              i_nxt = '0;
              j_nxt = '0;
              state_nxt = (n == '0) ? S_RG_RD : S_CK_RI;
            end else begin
              strobe_nxt = 1'b1;
              status_nxt = STAT_OK;
              val_nxt    = '0;
              err_nxt    = '0;
              state_nxt  = S_IDLE;
            end
          end
        end else if (!ready_r) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_NOT_READY;
          val_nxt    = '0;
          err_nxt    = '0;
          state_nxt  = S_IDLE;
        end else begin
          i_nxt     = n;
          state_nxt = S_EV_R0;
        end
      end

      // pairwise scan for coincident nodes: hold node i, stream node j
      S_CK_RI: begin
        mctl.node_raddr = i_r;
        j_nxt     = i_r + 1'b1;
        state_nxt = S_CK_LI;
      end
      S_CK_LI: begin
        ni_nxt          = node_rdata;
        mctl.node_raddr = j_r;
        state_nxt       = S_CK_CMP;
      end
      S_CK_CMP: begin
        if (node_rdata == ni_r) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_COINCIDENT;
          val_nxt    = '0;
          err_nxt    = '0;
          state_nxt  = S_IDLE;
        end else if (j_r == n) begin
          if (int'(i_r) == int'(n) - 1) begin
            j_nxt     = '0;
            state_nxt = S_RG_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_CK_RI;
          end
        end else begin
          mctl.node_raddr = j_r + 1'b1;
          j_nxt           = j_r + 1'b1;
        end
      end

      // function sample of x_r: square, denominator, reciprocal divide
      S_RG_RD: begin
        mctl.node_raddr = j_r;
        state_nxt       = S_RG_LD;
      end
      S_RG_LD: begin
        x_nxt     = node_rdata;
        state_nxt = S_RG_MS;
      end
      S_RG_MS: begin
        mreq.start = 1'b1;
        mreq.a_mag = VAL_W'(x_mag);
        mreq.b_mag = DIFF_W'(x_mag);
        state_nxt  = S_RG_MW;
      end
      S_RG_MW: begin
        if (mrsp.done) begin
          sq_nxt    = rg_sq;
          state_nxt = S_RG_DEN;
        end
      end
      S_RG_DEN: begin
        den_nxt   = VAL_ONE + VAL_W'(sq_r * VAL_W'(RUNGE_K));
        state_nxt = S_RG_DS;
      end
      S_RG_DS: begin
        dreq.start = 1'b1;
        dreq.a     = VAL_ONE;
        dreq.b     = den_r;
        dreq.sh_dd = 1'b0;
        state_nxt  = S_RG_DW;
      end
      S_RG_DW: begin
        if (drsp.done) begin
          fx_nxt    = drsp.q;
          state_nxt = S_RG_END;
        end
      end
      S_RG_END: begin
        if (op_r == OP_EVAL) begin
          state_nxt = S_EV_E1;
        end else begin
          mctl.diff_we    = 1'b1;
          mctl.diff_waddr = j_r;
          mctl.diff_wdata = fx_r;
          if (j_r == n) begin
            if (n == '0) begin
              ready_nxt  = 1'b1;
              strobe_nxt = 1'b1;
              status_nxt = STAT_OK;
              val_nxt    = '0;
              err_nxt    = '0;
              state_nxt  = S_IDLE;
            end else begin
              i_nxt     = NODE_AW'(1);
              j_nxt     = n;
              state_nxt = S_DD_RA;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_RG_RD;
          end
        end
      end

      // in-place column update, top entry downward
      S_DD_RA: begin
        mctl.diff_raddr = j_r;
        mctl.node_raddr = j_r;
        state_nxt       = S_DD_RB;
      end
      S_DD_RB: begin
        a_nxt           = diff_rdata;
        ni_nxt          = node_rdata;
        mctl.diff_raddr = j_r - 1'b1;
        mctl.node_raddr = j_r - i_r;
        state_nxt       = S_DD_RC;
      end
      S_DD_RC: begin
        num_nxt   = sat_sub(a_r, diff_rdata);
        d_nxt     = dd_d;
        state_nxt = S_DD_DS;
      end
      S_DD_DS: begin
        dreq.start = 1'b1;
        dreq.a     = num_r;
        dreq.b     = VAL_W'(signed'(d_r));
        dreq.sh_dd = 1'b1;
        state_nxt  = S_DD_DW;
      end
      S_DD_DW: begin
        if (drsp.done) begin
          mctl.diff_we    = 1'b1;
          mctl.diff_waddr = j_r;
          mctl.diff_wdata = drsp.q;
          if (j_r == i_r) begin
            if (i_r == n) begin
              ready_nxt  = 1'b1;
              strobe_nxt = 1'b1;
              status_nxt = STAT_OK;
              val_nxt    = '0;
              err_nxt    = '0;
              state_nxt  = S_IDLE;
            end else begin
              i_nxt     = i_r + 1'b1;
              j_nxt     = n;
              state_nxt = S_DD_RA;
            end
          end else begin
            j_nxt     = j_r - 1'b1;
            state_nxt = S_DD_RA;
          end
        end
      end

      // Horner walk from the top coefficient
      S_EV_R0: begin
        mctl.diff_raddr = n;
        state_nxt       = S_EV_L0;
      end
      S_EV_L0: begin
        v_nxt     = diff_rdata;
        state_nxt = (i_r == '0) ? S_RG_MS : S_EV_RA;
      end
      S_EV_RA: begin
        mctl.diff_raddr = i_r - 1'b1;
        mctl.node_raddr = i_r - 1'b1;
        state_nxt       = S_EV_RB;
      end
      S_EV_RB: begin
        a_nxt     = diff_rdata;
        d_nxt     = ev_d;
        state_nxt = S_EV_MS;
      end
      S_EV_MS: begin
        mreq.start = 1'b1;
        mreq.a_mag = mag64(v_r);
        mreq.b_mag = d_mag;
        neg_nxt    = v_r[VAL_W-1] ^ d_r[DIFF_W-1];
        state_nxt  = S_EV_MW;
      end
      S_EV_MW: begin
        if (mrsp.done) begin
          rm_nxt    = mul_ovf ? {VAL_W{1'b1}} : mul_tsh[VAL_W-1:0];
          state_nxt = S_EV_NG;
        end
      end
      S_EV_NG: begin
        p_nxt     = signed_sat(neg_r, rm_r);
        state_nxt = S_EV_AD;
      end
      S_EV_AD: begin
        v_nxt     = sat_add(a_r, p_r);
        i_nxt     = i_r - 1'b1;
        state_nxt = (i_r == NODE_AW'(1)) ? S_RG_MS : S_EV_RA;
      end
      S_EV_E1: begin
        e_nxt     = {fx_r[VAL_W-1], fx_r} - {v_r[VAL_W-1], v_r};
        state_nxt = S_EV_E2;
      end
      S_EV_E2: begin
        strobe_nxt = 1'b1;
        status_nxt = STAT_OK;
        val_nxt    = v_r;
        err_nxt    = (|e_mag[VAL_W:VAL_W-1]) ? {(VAL_W-1){1'b1}} : e_mag[VAL_W-2:0];
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      degree_r <= DEGREE_RESET;
      ready_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      degree_r <= degree_nxt;
      ready_r  <= ready_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    x_r      <= x_nxt;
    ni_r     <= ni_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    a_r      <= a_nxt;
    v_r      <= v_nxt;
    num_r    <= num_nxt;
    sq_r     <= sq_nxt;
    den_r    <= den_nxt;
    fx_r     <= fx_nxt;
    rm_r     <= rm_nxt;
    p_r      <= p_nxt;
    d_r      <= d_nxt;
    neg_r    <= neg_nxt;
    e_r      <= e_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
    err_r    <= err_nxt;
  end

  assign out_strobe             = strobe_r;
  assign out_status             = status_r;
  assign out_interpolated_value = val_r;
  assign out_error_magnitude    = err_r;

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accepted beat did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != STAT_OK) |->
      (out_interpolated_value == '0 && out_error_magnitude == '0))
    else $error("non-ok result carries payload");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !ready_r)
    else $error("degree write left table ready");

endmodule
`default_nettype wire

### sv/nie_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nie_mem
// Node position store and divided-difference table, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module nie_mem (
  input  wire logic                               clk,
  input  wire nie_pkg::mem_ctl_t                  ctl,
  output logic [nie_pkg::POS_W-1:0]               node_rdata,
  output logic [nie_pkg::VAL_W-1:0]               diff_rdata
);
  import nie_pkg::*;

  logic [POS_W-1:0] node_mem [MAX_NODES];
  logic [VAL_W-1:0] diff_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (ctl.node_we) begin
      node_mem[ctl.node_waddr] <= ctl.node_wdata;
    end
    node_rdata <= node_mem[ctl.node_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.diff_we) begin
      diff_mem[ctl.diff_waddr] <= ctl.diff_wdata;
    end
    diff_rdata <= diff_mem[ctl.diff_raddr];
  end

endmodule
`default_nettype wire

### sv/nie_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nie_mul
// Unsigned 64 x 33 multiplier built from one 32 x 33 array used twice;
// low partial, high partial and their sum are registered in turn.
// ----------------------------------------------------------------------------
module nie_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nie_pkg::mul_req_t req,
  output nie_pkg::mul_rsp_t      rsp
);
  import nie_pkg::*;

  localparam int HALF_W = VAL_W / 2;

  logic [1:0]               step_r;
  logic [VAL_W-1:0]         a_r;
  logic [DIFF_W-1:0]        b_r;
  logic [HALF_W+DIFF_W-1:0] lo_r, hi_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     done_r;
  logic [HALF_W-1:0]        op_a;
  logic [HALF_W+DIFF_W-1:0] part;

  assign op_a = (step_r == 2'd2) ? a_r[VAL_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign part = op_a * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == 2'd3);
      unique case (step_r)
        2'd0: if (req.start) step_r <= 2'd1;
        2'd1: step_r <= 2'd2;
        2'd2: step_r <= 2'd3;
        2'd3: step_r <= 2'd0;
        default: step_r <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == 2'd0 && req.start) begin
      a_r <= req.a_mag;
      b_r <= req.b_mag;
    end
    if (step_r == 2'd1) lo_r <= part;
    if (step_r == 2'd2) hi_r <= part;
    if (step_r == 2'd3) prod_r <= (PROD_W'(hi_r) << HALF_W) + PROD_W'(lo_r);
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule
`default_nettype wire

### sv/nie_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nie_div
// Restoring divider, one quotient bit a cycle: round(a * 2^sh / b) with
// half-away-from-zero rounding and saturation to the signed 64-bit range.
// ----------------------------------------------------------------------------
module nie_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nie_pkg::div_req_t req,
  output nie_pkg::div_rsp_t      rsp
);
  import nie_pkg::*;

  div_phase_t             phase_r;
  logic [DIV_CW-1:0]      cnt_r;
  logic [DIV_STEPS-1:0]   num_r;
  logic [VAL_W-1:0]       r_r, q_r, bm_r, m_r, qout_r;
  logic                   ovf_r, neg_r, zero_r, done_r;
  logic [VAL_W:0]         rs, rsub, qs;
  logic                   ge, rnd;
  logic [VAL_W-1:0]       am, bm;

  assign am   = mag64(req.a);
  assign bm   = mag64(req.b);
  assign rs   = {r_r, num_r[DIV_STEPS-1]};
  assign rsub = rs - {1'b0, bm_r};
  assign ge   = rs >= {1'b0, bm_r};
  assign rnd  = {r_r, 1'b0} >= {1'b0, bm_r};
  assign qs   = {1'b0, q_r} + (VAL_W+1)'(rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DP_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        DP_IDLE:  if (req.start) phase_r <= DP_RUN;
        DP_RUN:   if (cnt_r == DIV_CW'(DIV_STEPS - 1)) phase_r <= DP_ROUND;
        DP_ROUND: phase_r <= DP_OUT;
        DP_OUT: begin
          phase_r <= DP_IDLE;
          done_r  <= 1'b1;
        end
        default:  phase_r <= DP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase_r)
      DP_IDLE: begin
        if (req.start) begin
          num_r  <= DIV_STEPS'(am) << (req.sh_dd ? DD_SH : FRACTION_BITS);
          bm_r   <= bm;
          neg_r  <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
          zero_r <= (bm == '0);
          r_r    <= '0;
          q_r    <= '0;
          ovf_r  <= 1'b0;
          cnt_r  <= '0;
        end
      end
      DP_RUN: begin
        num_r <= num_r << 1;
        r_r   <= ge ? rsub[VAL_W-1:0] : rs[VAL_W-1:0];
        q_r   <= {q_r[VAL_W-2:0], ge};
        ovf_r <= ovf_r | q_r[VAL_W-1];
        cnt_r <= cnt_r + 1'b1;
      end
      DP_ROUND: m_r <= (ovf_r | qs[VAL_W]) ? {VAL_W{1'b1}} : qs[VAL_W-1:0];
      DP_OUT:   qout_r <= zero_r ? '0 : signed_sat(neg_r, m_r);
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.q    = qout_r;

endmodule
`default_nettype wire

### dv/newton_interpolation_error_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_interpolation_error_tb
// Self-checking bench for the Newton interpolation error block. Sends node
// loads, table builds and evaluations through the command port. Also writes
// the degree register between phases. A scoreboard predicts every status
// beat bit for bit and checks the beats in order.
// ----------------------------------------------------------------------------
module newton_interpolation_error_tb;
  import nie_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int ITEM_TARGET  = 1700;

  typedef struct {
    status_t            st;
    logic [VAL_W-1:0]   val;
    logic [VAL_W-2:0]   err;
  } status_beat_t;

  class interp_scoreboard;
    logic [POS_W-1:0]   nodes [MAX_NODES];
    logic [VAL_W-1:0]   coeffs [MAX_NODES];
    bit                 ready;
    int unsigned        deg;
    status_beat_t       pending_q [$];
    int                 errors;
    int                 seen [4];

    function new();
      ready = 0;
      deg = 8;
      errors = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function automatic logic [VAL_W-1:0] mag(logic [VAL_W-1:0] a);
      return a[VAL_W-1] ? ~a + 1'b1 : a;
    endfunction

    function automatic logic [VAL_W-1:0] clamp(bit neg, logic [VAL_W-1:0] m);
      if (!neg) return m[VAL_W-1] ? VAL_MAX : m;
      if (m[VAL_W-1]) return VAL_MIN;
      return ~m + 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] add_sat(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
      return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sub_sat(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? VAL_MIN : VAL_MAX;
      return s[VAL_W-1:0];
    endfunction

    // round(a*b / 2^sh), half away from zero
    function automatic logic [VAL_W-1:0] scaled_product(logic [VAL_W-1:0] a,
                                                         logic [VAL_W-1:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      return clamp(a[VAL_W-1] ^ b[VAL_W-1], (|p[127:64]) ? '1 : p[63:0]);
    endfunction

    // round(a*2^sh / b); zero divisor yields zero
    function automatic logic [VAL_W-1:0] scaled_quotient(logic [VAL_W-1:0] a,
                                                          logic [VAL_W-1:0] b, int sh);
      logic [127:0] num, q, r;
      logic [63:0]  bm;
      bm = mag(b);
      if (bm == 0) return '0;
      num = {64'd0, mag(a)} << sh;
      q = num / {64'd0, bm};
      r = num % {64'd0, bm};
      if (r[63:0] >= bm - r[63:0]) q = q + 1;
      return clamp(a[VAL_W-1] ^ b[VAL_W-1], (|q[127:64]) ? '1 : q[63:0]);
    endfunction

    function automatic logic [VAL_W-1:0] sext(logic [POS_W-1:0] p);
      return {{(VAL_W-POS_W){p[POS_W-1]}}, p};
    endfunction

    function automatic logic [VAL_W-1:0] runge_at(logic [VAL_W-1:0] x);
      logic [63:0] m, sq, den;
      m = mag(x);
      sq = (m * m + (64'd1 << (RUNGE_SH - 1))) >> RUNGE_SH;
      den = VAL_ONE + 64'(RUNGE_K) * sq;
      return scaled_quotient(VAL_ONE, den, FRACTION_BITS);
    endfunction

    function automatic status_t build_coeffs(int n);
      logic [VAL_W-1:0] t [MAX_NODES];
      for (int i = 0; i <= n; i++)
        for (int j = i + 1; j <= n; j++)
          if (nodes[i] == nodes[j]) return STAT_COINCIDENT;
      for (int j = 0; j <= n; j++) t[j] = runge_at(sext(nodes[j]));
      for (int i = 1; i <= n; i++)
        for (int j = n; j >= i; j--)
          t[j] = scaled_quotient(sub_sat(t[j], t[j-1]),
                                 sext(nodes[j]) - sext(nodes[j-i]), DD_SH);
      for (int j = 0; j <= n; j++) coeffs[j] = t[j];
      ready = 1;
      return STAT_OK;
    endfunction

    function void set_degree(logic [DEG_W-1:0] v);
      deg = v;
      ready = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_item(logic op, logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos);
      status_beat_t b;
      logic [VAL_W-1:0] x, v, fx;
      logic [VAL_W:0]   diff;
      int n;
      n = (deg > MAX_NODES - 1) ? MAX_NODES - 1 : deg;
      b.st = STAT_OK;
      b.val = '0;
      b.err = '0;
      if (op == OP_LOAD) begin
        if (idx > n) begin
          b.st = STAT_INDEX;
        end else begin
          nodes[idx] = pos;
          ready = 0;
          if (idx == n) b.st = build_coeffs(n);
        end
      end else if (!ready) begin
        b.st = STAT_NOT_READY;
      end else begin
        x = sext(pos);
        v = coeffs[n];
        for (int i = n; i > 0; i--)
          v = add_sat(coeffs[i-1], scaled_product(v, x - sext(nodes[i-1]), DD_SH));
        fx = runge_at(x);
        diff = {fx[VAL_W-1], fx} - {v[VAL_W-1], v};
        if (diff[VAL_W]) diff = -diff;
        b.val = v;
        b.err = (diff > {1'b0, VAL_MAX}) ? VAL_MAX[VAL_W-2:0] : diff[VAL_W-2:0];
      end
      pending_q.push_back(b);
    endfunction

    function void check_beat(logic [1:0] st, logic [VAL_W-1:0] val, logic [VAL_W-2:0] err);
      status_beat_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected status beat: status=%0d value=%0h", st, val);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      seen[e.st]++;
      if (st != e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (val != e.val) begin
        $error("interpolated_value: expected %0h, got %0h", e.val, val);
        errors++;
      end
      if (err != e.err) begin
        $error("error_magnitude: expected %0h, got %0h", e.err, err);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_op;
  logic [IDX_W-1:0]     in_node_index;
  logic [POS_W-1:0]     in_position;
  logic                 out_strobe;
  logic [1:0]           out_status;
  logic [VAL_W-1:0]     out_interpolated_value;
  logic [VAL_W-2:0]     out_error_magnitude;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [DEG_W-1:0]     cfg_degree;

  interp_scoreboard sb;
  int items_sent;
  int gap_pct;
  int cycles = 0;
  int deg_writes;

  newton_interpolation_error u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_op                  (in_op),
    .in_node_index          (in_node_index),
    .in_position            (in_position),
    .out_strobe             (out_strobe),
    .out_status             (out_status),
    .out_interpolated_value (out_interpolated_value),
    .out_error_magnitude    (out_error_magnitude),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_degree             (cfg_degree)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("newton_interpolation_error_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_beat(out_status, out_interpolated_value, out_error_magnitude);
  end

  task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_node_index <= idx;
    in_position   <= pos;
    do @(posedge clk); while (busy);
    sb.note_item(op, idx, pos);
    items_sent++;
    // sender idling: light, then heavy, then none
    gap_pct = (items_sent < ITEM_TARGET / 3) ? 12 :
              (items_sent < 2 * ITEM_TARGET / 3) ? 59 : 0;
  endtask

  task automatic write_degree(logic [DEG_W-1:0] v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_degree <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_degree(v);
    deg_writes++;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(3))
      0: return $urandom;
      1: return POS_W'($urandom_range(32'h8000_0000) - 32'h4000_0000);
      2: return POS_W'($urandom_range(32'h0800_0000) - 32'h0400_0000);
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // Well-formed phase: set degree, load all nodes, evaluate; some noise.
  task automatic run_phase(int n);
    logic [POS_W-1:0] pos [MAX_NODES];
    int order [MAX_NODES];
    int k, tmp, r;
    bit dup;
    write_degree(DEG_W'(n));
    for (int i = 0; i <= n; i++) begin
      do begin
        pos[i] = pick_position();
        dup = 0;
        for (int j = 0; j < i; j++) if (pos[j] == pos[i]) dup = 1;
      end while (dup);
    end
    if (n > 0 && $urandom_range(9) == 0) pos[n] = pos[$urandom_range(n - 1)];
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      r = $urandom_range(i);
      tmp = order[i];
      order[i] = order[r];
      order[r] = tmp;
    end
    if ($urandom_range(3) == 0) send_item(OP_EVAL, IDX_W'($urandom), pick_position());
    for (int i = 0; i < n; i++) begin
      send_item(OP_LOAD, IDX_W'(order[i]), pos[order[i]]);
      if (n < MAX_NODES - 1 && $urandom_range(9) == 0)
        send_item(OP_LOAD, IDX_W'($urandom_range(n + 1, MAX_NODES - 1)), $urandom);
    end
    send_item(OP_LOAD, IDX_W'(n), pos[n]);
    k = $urandom_range(4, 14);
    for (int e = 0; e < k; e++) begin
      if ($urandom_range(3) == 0)
        send_item(OP_EVAL, IDX_W'($urandom), pos[$urandom_range(n)]);
      else
        send_item(OP_EVAL, IDX_W'($urandom), pick_position());
      // drop readiness by reloading a node, then rebuild
      if (n > 0 && $urandom_range(15) == 0) begin
        tmp = $urandom_range(n - 1);
        send_item(OP_LOAD, IDX_W'(tmp), pos[tmp]);
        send_item(OP_EVAL, IDX_W'($urandom), pick_position());
        send_item(OP_LOAD, IDX_W'(n), pos[n]);
      end
    end
  endtask

  initial begin
    logic [POS_W-1:0] dir_nodes [9];
    int r;
    sb = new();
    items_sent = 0;
    gap_pct = 12;
    deg_writes = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_LOAD;
    in_node_index = '0;
    in_position = '0;
    cfg_valid = 1'b0;
    cfg_degree = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: not ready, index beyond degree, extreme nodes at reset degree
    dir_nodes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h4000_0000,
                  32'hc000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h2000_0000,
                  32'h1000_0000};
    send_item(OP_EVAL, 4'hf, 32'h0000_0000);
    send_item(OP_LOAD, 4'd9, 32'h1234_5678);
    send_item(OP_LOAD, 4'hf, 32'hffff_ffff);
    for (int i = 0; i < 9; i++) send_item(OP_LOAD, IDX_W'(i), dir_nodes[i]);
    send_item(OP_EVAL, 4'h0, 32'h8000_0000);
    send_item(OP_EVAL, 4'h0, 32'h7fff_ffff);
    send_item(OP_EVAL, 4'h0, 32'h0000_0000);
    send_item(OP_EVAL, 4'h0, 32'h1234_5678);
    // coincident pair, then a clean rebuild at degree one
    write_degree(DEG_W'(1));
    send_item(OP_LOAD, 4'd0, 32'h0000_0005);
    send_item(OP_LOAD, 4'd1, 32'h0000_0005);
    send_item(OP_EVAL, 4'h0, 32'h0000_0005);
    send_item(OP_LOAD, 4'd1, 32'h0000_0006);
    send_item(OP_EVAL, 4'h0, 32'h7fff_ffff);

    run_phase(MAX_NODES - 1);
    run_phase(0);
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 4)       run_phase(MAX_NODES - 1);
      else if (r < 10) run_phase(0);
      else if (r < 70) run_phase($urandom_range(1, 4));
      else             run_phase($urandom_range(5, 9));
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d degree writes", items_sent, deg_writes);
    $display("beats: %0d ok, %0d not ready, %0d coincident, %0d index beyond degree",
             sb.seen[STAT_OK], sb.seen[STAT_NOT_READY], sb.seen[STAT_COINCIDENT],
             sb.seen[STAT_INDEX]);
    if (sb.errors == 0)
      $display("newton_interpolation_error_tb: done, clean");
    else
      $display("newton_interpolation_error_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
sv/nie_pkg.sv
sv/nie_mem.sv
sv/nie_mul.sv
sv/nie_div.sv
sv/newton_interpolation_error.sv
dv/newton_interpolation_error_tb.sv
